// File: src/dau_pkg.sv
// Shared constants and elaboration-time table functions for the dihedral angle unit.
package dau_pkg;

   // Angle accumulator fraction bits, CORDIC depth and normal scaling target.
   localparam int ZQ           = 60;
   localparam int CORDIC_STEPS = 40;
   localparam int NORM_BITS    = 30;
   localparam int SQRT_STEPS   = 32;

   // Register stages ahead of the square root, between it and the CORDIC, and after it.
   localparam int FRONT_STAGES = 14;
   localparam int MID_STAGES   = 3;
   localparam int BACK_STAGES  = 2;
   localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + MID_STAGES + CORDIC_STEPS
                                 + BACK_STAGES;

   // Restoring divider, used only to build constant tables at elaboration.
   function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Arctangent of 1/n in Q60 from the truncated series.
   function automatic logic [63:0] atan_inv(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] n2;
      logic [63:0] sum;
      logic [63:0] t;
      int k;
      p   = const_div(64'd1 << ZQ, n);
      n2  = n * n;
      sum = '0;
      k   = 0;
      while (p != 64'd0) begin
         t = const_div(p, 64'(2 * k + 1));
         if (k[0]) sum = sum - t;
         else sum = sum + t;
         p = const_div(p, n2);
         k++;
      end
      return sum;
   endfunction

   // Arctangent of 2^-i in Q60 from the truncated series.
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] t;
      int k;
      p   = 64'd1 << (ZQ - i);
      sum = '0;
      k   = 0;
      while (p != 64'd0) begin
         t = const_div(p, 64'(2 * k + 1));
         if (k[0]) sum = sum - t;
         else sum = sum + t;
         p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
         k++;
      end
      return sum;
   endfunction

   // One CORDIC angle entry; entry zero is pi/4 by Machin's formula.
   function automatic logic [63:0] atan_entry(input int i);
      logic [63:0] v;
      if (i == 0) v = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
      else v = atan_pow2(i);
      return v;
   endfunction

endpackage

// File: src/dau_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module dau_isqrt #(
   parameter int SIDE_W = 71
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [63:0]       in_n,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = dau_pkg::SQRT_STEPS;

   logic              vld_ff  [STEPS];
   logic [63:0]       n_ff    [STEPS];
   logic [63:0]       res_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   genvar k;
   for (k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic              vld_p;
      logic [63:0]       n_p;
      logic [63:0]       res_p;
      logic [SIDE_W-1:0] side_p;
      logic [63:0]       trial;
      logic [63:0]       n_in;
      logic [63:0]       res_in;

      if (k == 0) begin : g_first
         assign vld_p  = in_valid;
         assign n_p    = in_n;
         assign res_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign n_p    = n_ff[k-1];
         assign res_p  = res_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // Subtract the trial value when it fits and set this root bit.
      always_comb begin
         trial = res_p + BIT;
         if (n_p >= trial) begin
            n_in   = n_p - trial;
            res_in = (res_p >> 1) + BIT;
         end else begin
            n_in   = n_p;
            res_in = res_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k] <= 1'b0;
         else vld_ff[k] <= vld_p;
         n_ff[k]    <= n_in;
         res_ff[k]  <= res_in;
         side_ff[k] <= side_p;
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][31:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: src/dau_cordic.sv
// Pipelined vectoring CORDIC that accumulates the angle of (x, y) in Q60.
module dau_cordic #(
   parameter int SIDE_W = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [63:0]  in_x,
   input  logic signed [63:0]  in_y,
   input  logic signed [63:0]  in_z,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic signed [63:0]  out_z,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int STEPS = dau_pkg::CORDIC_STEPS;

   logic               vld_ff  [STEPS];
   logic signed [63:0] x_ff    [STEPS];
   logic signed [63:0] y_ff    [STEPS];
   logic signed [63:0] z_ff    [STEPS];
   logic [SIDE_W-1:0]  side_ff [STEPS];

   genvar i;
   for (i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [63:0] ANG = signed'(dau_pkg::atan_entry(i));
      logic               vld_p;
      logic signed [63:0] x_p;
      logic signed [63:0] y_p;
      logic signed [63:0] z_p;
      logic [SIDE_W-1:0]  side_p;
      logic signed [63:0] x_in;
      logic signed [63:0] y_in;
      logic signed [63:0] z_in;

      if (i == 0) begin : g_first
         assign vld_p  = in_valid;
         assign x_p    = in_x;
         assign y_p    = in_y;
         assign z_p    = in_z;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[i-1];
         assign x_p    = x_ff[i-1];
         assign y_p    = y_ff[i-1];
         assign z_p    = z_ff[i-1];
         assign side_p = side_ff[i-1];
      end

      // Rotate toward the x axis; the sign of y picks the direction.
      always_comb begin
         if (y_p >= 0) begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + ANG;
         end else begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[i] <= 1'b0;
         else vld_ff[i] <= vld_p;
         x_ff[i]    <= x_in;
         y_ff[i]    <= y_in;
         z_ff[i]    <= z_in;
         side_ff[i] <= side_p;
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_z     = z_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: src/dihedral_angle_unit.sv
// Top level of the dihedral angle unit: differences, normals, dot and cross, and final rounding.
//
// Fully pipelined: one request is taken every clock while busy is low (busy is high only
// during reset). Each request passes through 14 stages of differences, cross products,
// normal scaling and dot/cross products, a 32-stage square root, 3 stages that align the
// (dot, cross length) pair, a 40-stage CORDIC and 2 stages of rounding, and its result
// appears with rsp_valid. Results cannot be held off by the receiver; rsp_valid is high for
// a single cycle per request. A zero plane normal gives rsp_degenerate high and an angle of
// zero.
module dihedral_angle_unit #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_p1_x,
   input  logic signed [31:0]         req_p1_y,
   input  logic signed [31:0]         req_p1_z,
   input  logic signed [31:0]         req_p2_x,
   input  logic signed [31:0]         req_p2_y,
   input  logic signed [31:0]         req_p2_z,
   input  logic signed [31:0]         req_p3_x,
   input  logic signed [31:0]         req_p3_y,
   input  logic signed [31:0]         req_p3_z,
   input  logic signed [31:0]         req_p4_x,
   input  logic signed [31:0]         req_p4_y,
   input  logic signed [31:0]         req_p4_z,
   output logic                       rsp_valid,
   output logic [ANGLE_FRAC_BITS+1:0] rsp_torsion_angle,
   output logic                       rsp_degenerate
);

   localparam int OW = ANGLE_FRAC_BITS + 2;
   localparam int ZQ = dau_pkg::ZQ;
   localparam int NB = dau_pkg::NORM_BITS;
   localparam int NFRONT = dau_pkg::FRONT_STAGES;
   localparam logic [63:0] HALF = 64'd1 << (ZQ - 1 - ANGLE_FRAC_BITS);
   localparam logic [63:0] PI_Q = (64'd4 * dau_pkg::atan_entry(0) + HALF)
                                  >> (ZQ - ANGLE_FRAC_BITS);
   localparam logic signed [63:0] HALF_PI = signed'(64'd2 * dau_pkg::atan_entry(0));
   localparam int SQ_SIDE = 1 + 6 + 64;

   // Bit length of a magnitude (position of the leading one plus one).
   function automatic logic [6:0] bit_len(input logic [66:0] v);
      logic [6:0] n;
      n = '0;
      for (int k = 0; k < 67; k++) begin
         if (v[k]) n = 7'(k + 1);
      end
      return n;
   endfunction

   // Requests are taken every cycle outside reset.
   assign busy = reset;

   // Valid bits of the front stages.
   logic vld_in [NFRONT];
   logic vld_ff [NFRONT];

   always_comb begin
      vld_in[0] = start & ~busy;
      for (int k = 1; k < NFRONT; k++) vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NFRONT; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < NFRONT; k++) vld_ff[k] <= vld_in[k];
      end
   end

   // Stage 1: register the request.
   logic signed [31:0] pt_in [4][3];
   logic signed [31:0] pt_ff [4][3];

   always_comb begin
      pt_in[0][0] = req_p1_x; pt_in[0][1] = req_p1_y; pt_in[0][2] = req_p1_z;
      pt_in[1][0] = req_p2_x; pt_in[1][1] = req_p2_y; pt_in[1][2] = req_p2_z;
      pt_in[2][0] = req_p3_x; pt_in[2][1] = req_p3_y; pt_in[2][2] = req_p3_z;
      pt_in[3][0] = req_p4_x; pt_in[3][1] = req_p4_y; pt_in[3][2] = req_p4_z;
   end

   always_ff @(posedge clock) pt_ff <= pt_in;

   // Stage 2: edge vectors b-a, c-b and d-c.
   logic signed [32:0] dif_in [3][3];
   logic signed [32:0] dif_ff [3][3];

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int c = 0; c < 3; c++) dif_in[e][c] = 33'(pt_ff[e+1][c]) - 33'(pt_ff[e][c]);
      end
   end

   always_ff @(posedge clock) dif_ff <= dif_in;

   // Stage 3: partial products of both cross products.
   logic signed [65:0] pp_in [2][3][2];
   logic signed [65:0] pp_ff [2][3][2];

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         for (int c = 0; c < 3; c++) begin
            pp_in[n][c][0] = dif_ff[n][(c+1)%3] * dif_ff[n+1][(c+2)%3];
            pp_in[n][c][1] = dif_ff[n][(c+2)%3] * dif_ff[n+1][(c+1)%3];
         end
      end
   end

   always_ff @(posedge clock) pp_ff <= pp_in;

   // Stage 4: exact normal components.
   logic signed [66:0] cmp_in [2][3];
   logic signed [66:0] cmp_ff [2][3];

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         for (int c = 0; c < 3; c++) cmp_in[n][c] = 67'(pp_ff[n][c][0]) - 67'(pp_ff[n][c][1]);
      end
   end

   always_ff @(posedge clock) cmp_ff <= cmp_in;

   // Stage 5: sign and magnitude of each component.
   logic [66:0] mag_in [2][3];
   logic [66:0] mag_ff [2][3];
   logic        neg_in [2][3];
   logic        neg_ff [2][3];

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         for (int c = 0; c < 3; c++) begin
            neg_in[n][c] = cmp_ff[n][c][66];
            mag_in[n][c] = cmp_ff[n][c][66] ? unsigned'(-cmp_ff[n][c]) : unsigned'(cmp_ff[n][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   // Stage 6: per-normal scale so that the largest magnitude fits the target width.
   logic [5:0]  shn_in [2];
   logic [5:0]  shn_ff [2];
   logic [66:0] mag6_ff [2][3];
   logic        neg6_ff [2][3];
   logic [6:0]  nlen [2];

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         nlen[n]   = bit_len(mag_ff[n][0] | mag_ff[n][1] | mag_ff[n][2]);
         shn_in[n] = (nlen[n] > 7'(NB)) ? 6'(nlen[n] - 7'(NB)) : 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      shn_ff  <= shn_in;
      mag6_ff <= mag_ff;
      neg6_ff <= neg_ff;
   end

   // Stage 7: scaled normals and the zero-normal flag.
   logic [29:0]        msc    [2][3];
   logic signed [30:0] tu_in  [2][3];
   logic signed [30:0] tu_ff  [2][3];
   logic               deg7_in;
   logic               deg7_ff;

   always_comb begin
      for (int n = 0; n < 2; n++) begin
         for (int c = 0; c < 3; c++) begin
            msc[n][c]   = 30'(mag6_ff[n][c] >> shn_ff[n]);
            tu_in[n][c] = neg6_ff[n][c] ? -signed'({1'b0, msc[n][c]}) : signed'({1'b0, msc[n][c]});
         end
      end
      deg7_in = ((msc[0][0] | msc[0][1] | msc[0][2]) == 30'd0) ||
                ((msc[1][0] | msc[1][1] | msc[1][2]) == 30'd0);
   end

   always_ff @(posedge clock) begin
      tu_ff   <= tu_in;
      deg7_ff <= deg7_in;
   end

   // Stage 8: all nine products of the scaled normals.
   logic signed [61:0] pr_in [3][3];
   logic signed [61:0] pr_ff [3][3];
   logic               deg8_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) pr_in[i][j] = tu_ff[0][i] * tu_ff[1][j];
      end
   end

   always_ff @(posedge clock) begin
      pr_ff   <= pr_in;
      deg8_ff <= deg7_ff;
   end

   // Stage 9: dot product and cross product of the normals.
   logic signed [63:0] dot9_in;
   logic signed [63:0] dot9_ff;
   logic signed [62:0] w_in [3];
   logic signed [62:0] w_ff [3];
   logic               deg9_ff;

   always_comb begin
      dot9_in = 64'(pr_ff[0][0]) + 64'(pr_ff[1][1]) + 64'(pr_ff[2][2]);
      w_in[0] = 63'(pr_ff[1][2]) - 63'(pr_ff[2][1]);
      w_in[1] = 63'(pr_ff[2][0]) - 63'(pr_ff[0][2]);
      w_in[2] = 63'(pr_ff[0][1]) - 63'(pr_ff[1][0]);
   end

   always_ff @(posedge clock) begin
      dot9_ff <= dot9_in;
      w_ff    <= w_in;
      deg9_ff <= deg8_ff;
   end

   // Stage 10: cross product magnitudes.
   logic [62:0]        wm_in [3];
   logic [62:0]        wm_ff [3];
   logic signed [63:0] dot10_ff;
   logic               deg10_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) wm_in[c] = w_ff[c][62] ? unsigned'(-w_ff[c]) : unsigned'(w_ff[c]);
   end

   always_ff @(posedge clock) begin
      wm_ff    <= wm_in;
      dot10_ff <= dot9_ff;
      deg10_ff <= deg9_ff;
   end

   // Stage 11: scale of the cross product.
   logic [6:0]         wlen;
   logic [5:0]         sc11_in;
   logic [5:0]         sc11_ff;
   logic [62:0]        wm11_ff [3];
   logic signed [63:0] dot11_ff;
   logic               deg11_ff;

   always_comb begin
      wlen    = bit_len(67'(wm_ff[0] | wm_ff[1] | wm_ff[2]));
      sc11_in = (wlen > 7'(NB)) ? 6'(wlen - 7'(NB)) : 6'd0;
   end

   always_ff @(posedge clock) begin
      sc11_ff  <= sc11_in;
      wm11_ff  <= wm_ff;
      dot11_ff <= dot10_ff;
      deg11_ff <= deg10_ff;
   end

   // Stage 12: scaled cross components.
   logic [29:0]        v_in [3];
   logic [29:0]        v_ff [3];
   logic [5:0]         sc12_ff;
   logic signed [63:0] dot12_ff;
   logic               deg12_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) v_in[c] = 30'(wm11_ff[c] >> sc11_ff);
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      sc12_ff  <= sc11_ff;
      dot12_ff <= dot11_ff;
      deg12_ff <= deg11_ff;
   end

   // Stage 13: squares.
   logic [59:0]        sq_in [3];
   logic [59:0]        sq_ff [3];
   logic [5:0]         sc13_ff;
   logic signed [63:0] dot13_ff;
   logic               deg13_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) sq_in[c] = v_ff[c] * v_ff[c];
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      sc13_ff  <= sc12_ff;
      dot13_ff <= dot12_ff;
      deg13_ff <= deg12_ff;
   end

   // Stage 14: sum of squares.
   logic [61:0]        sum_in;
   logic [61:0]        sum_ff;
   logic [5:0]         sc14_ff;
   logic signed [63:0] dot14_ff;
   logic               deg14_ff;

   assign sum_in = 62'(sq_ff[0]) + 62'(sq_ff[1]) + 62'(sq_ff[2]);

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      sc14_ff  <= sc13_ff;
      dot14_ff <= dot13_ff;
      deg14_ff <= deg13_ff;
   end

   // Length of the cross product.
   logic               sq_vld;
   logic [31:0]        sq_root;
   logic [SQ_SIDE-1:0] sq_side;

   dau_isqrt #(
      .SIDE_W (SQ_SIDE)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[NFRONT-1]),
      .in_n      (64'(sum_ff)),
      .in_side   ({deg14_ff, sc14_ff, dot14_ff}),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Stage A: magnitudes of the pair (dot, cross length).
   logic               va_ff;
   logic [63:0]        ux_in;
   logic [63:0]        ux_ff;
   logic [63:0]        uy_in;
   logic [63:0]        uy_ff;
   logic               xneg_ff;
   logic               dega_ff;
   logic signed [63:0] sq_dot;
   logic [5:0]         sq_sc;

   always_comb begin
      sq_dot = signed'(sq_side[63:0]);
      sq_sc  = sq_side[69:64];
      ux_in  = sq_dot[63] ? unsigned'(-sq_dot) : unsigned'(sq_dot);
      uy_in  = 64'(sq_root) << sq_sc;
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= sq_vld;
      ux_ff   <= ux_in;
      uy_ff   <= uy_in;
      xneg_ff <= sq_dot[63];
      dega_ff <= sq_side[70];
   end

   // Stage B: joint shift that puts the larger magnitude in [2^58, 2^59).
   localparam logic [6:0] TOP_LEN = 7'd59;
   logic        vb_ff;
   logic [63:0] mx;
   logic [6:0]  mlen;
   logic [6:0]  rsh_in;
   logic [6:0]  rsh_ff;
   logic [6:0]  lsh_in;
   logic [6:0]  lsh_ff;
   logic        zero_in;
   logic        zero_ff;
   logic [63:0] uxb_ff;
   logic [63:0] uyb_ff;
   logic        xnegb_ff;
   logic        degb_ff;

   always_comb begin
      mx      = (ux_ff > uy_ff) ? ux_ff : uy_ff;
      mlen    = bit_len(67'(mx));
      zero_in = (mx == 64'd0);
      rsh_in  = (mlen > TOP_LEN) ? mlen - TOP_LEN : 7'd0;
      lsh_in  = (mlen < TOP_LEN) ? TOP_LEN - mlen : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
      rsh_ff   <= rsh_in;
      lsh_ff   <= lsh_in;
      zero_ff  <= zero_in;
      uxb_ff   <= ux_ff;
      uyb_ff   <= uy_ff;
      xnegb_ff <= xneg_ff;
      degb_ff  <= dega_ff;
   end

   // Stage C: apply the shift; a negative dot is turned by -pi/2.
   logic               vc_ff;
   logic [63:0]        nx;
   logic [63:0]        ny;
   logic signed [63:0] cx_in;
   logic signed [63:0] cx_ff;
   logic signed [63:0] cy_in;
   logic signed [63:0] cy_ff;
   logic signed [63:0] base_in;
   logic signed [63:0] base_ff;
   logic [1:0]         flg_ff;

   always_comb begin
      nx = (uxb_ff >> rsh_ff) << lsh_ff;
      ny = (uyb_ff >> rsh_ff) << lsh_ff;
      if (xnegb_ff) begin
         cx_in   = signed'(ny);
         cy_in   = signed'(nx);
         base_in = HALF_PI;
      end else begin
         cx_in   = signed'(nx);
         cy_in   = signed'(ny);
         base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      base_ff <= base_in;
      flg_ff  <= {degb_ff, zero_ff};
   end

   // Angle of the pair.
   logic               cd_vld;
   logic signed [63:0] cd_z;
   logic [1:0]         cd_flg;

   dau_cordic #(
      .SIDE_W (2)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_x      (cx_ff),
      .in_y      (cy_ff),
      .in_z      (base_ff),
      .in_side   (flg_ff),
      .out_valid (cd_vld),
      .out_z     (cd_z),
      .out_side  (cd_flg)
   );

   // Stage D: clamp below at zero; degenerate and empty pairs give zero.
   logic        vd_ff;
   logic [63:0] ang_in;
   logic [63:0] ang_ff;
   logic        degd_ff;

   assign ang_in = (cd_z < 0 || cd_flg[1] || cd_flg[0]) ? 64'd0 : unsigned'(cd_z);

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else vd_ff <= cd_vld;
      ang_ff  <= ang_in;
      degd_ff <= cd_flg[1];
   end

   // Stage E: round half up to the output grid and clamp at pi.
   logic          ve_ff;
   logic [63:0]   q_rnd;
   logic [OW-1:0] q_in;
   logic [OW-1:0] q_ff;
   logic          dege_ff;

   always_comb begin
      q_rnd = (ang_ff + HALF) >> (ZQ - ANGLE_FRAC_BITS);
      q_in  = (q_rnd > PI_Q) ? OW'(PI_Q) : OW'(q_rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else ve_ff <= vd_ff;
      q_ff    <= q_in;
      dege_ff <= degd_ff;
   end

   assign rsp_valid         = ve_ff;
   assign rsp_torsion_angle = q_ff;
   assign rsp_degenerate    = dege_ff;

endmodule

// File: src/dau_checker.sv
// Port-level checker for the dihedral angle unit and its bind to the top level.
module dau_checker #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic signed [31:0]         req_p1_x,
   input logic signed [31:0]         req_p1_y,
   input logic signed [31:0]         req_p1_z,
   input logic signed [31:0]         req_p2_x,
   input logic signed [31:0]         req_p2_y,
   input logic signed [31:0]         req_p2_z,
   input logic                       rsp_valid,
   input logic [ANGLE_FRAC_BITS+1:0] rsp_torsion_angle,
   input logic                       rsp_degenerate
);

   localparam int LAT = dau_pkg::LATENCY;

   logic accepted;
   logic p12_same;

   assign accepted = start && !busy;
   assign p12_same = (req_p1_x == req_p2_x) && (req_p1_y == req_p2_y) && (req_p1_z == req_p2_z);

   // Every request yields its result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##LAT rsp_valid)
      else $error("request produced no result after the pipeline latency");

   // No result appears without a matching request.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accepted, LAT))
      else $error("result without a request");

   // A repeated first point collapses the first normal.
   a_coincident_degenerate: assert property (@(posedge clock) disable iff (reset)
      (accepted && p12_same) |-> ##LAT (rsp_valid && rsp_degenerate))
      else $error("coincident points not flagged degenerate");

   // A degenerate result carries a zero angle.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_torsion_angle == '0))
      else $error("degenerate result with nonzero angle");

endmodule

bind dihedral_angle_unit dau_checker #(
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_dau_checker (.*);

// File: sim/tb_dihedral_angle_unit.sv
// Self-checking testbench for the dihedral angle unit with a bit-exact torsion angle predictor.
`timescale 1ns / 1ps

module tb_dihedral_angle_unit;

   localparam int ANGLE_BITS  = 16;
   localparam int ANGLE_W     = ANGLE_BITS + 2;
   localparam int Q_ANGLE     = 60;
   localparam int ROTATIONS   = 40;
   localparam int SCALE_BITS  = 30;
   localparam int RANDOM_REQS = 1900;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 150;
   localparam int ONE         = 65536;

   typedef logic [11:0][31:0]     quad_type;
   typedef logic signed [127:0]   wide_type;
   typedef logic [2:0][63:0]      vec3_type;
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               degen;
   } torsion_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic rsp_valid;
   logic [ANGLE_W-1:0] rsp_torsion_angle;
   logic rsp_degenerate;
   quad_type drv_quad;

   quad_type      pending_quads[$];
   torsion_type   expected_angles[$];
   longint        atan_q60[ROTATIONS];
   int            errors;
   int            idle_cycles;
   int            burst_left;
   int            gap_left;
   torsion_type   predicted;
   torsion_type   oldest;

   dihedral_angle_unit #(.ANGLE_FRAC_BITS(ANGLE_BITS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_p1_x(drv_quad[0]), .req_p1_y(drv_quad[1]), .req_p1_z(drv_quad[2]),
      .req_p2_x(drv_quad[3]), .req_p2_y(drv_quad[4]), .req_p2_z(drv_quad[5]),
      .req_p3_x(drv_quad[6]), .req_p3_y(drv_quad[7]), .req_p3_z(drv_quad[8]),
      .req_p4_x(drv_quad[9]), .req_p4_y(drv_quad[10]), .req_p4_z(drv_quad[11]),
      .rsp_valid(rsp_valid), .rsp_torsion_angle(rsp_torsion_angle),
      .rsp_degenerate(rsp_degenerate)
   );

   always #1 clock = ~clock;

   // Arctangent series terms in Q60, alternating and truncated.
   function automatic longint unsigned arctan_series(input longint unsigned first,
                                                     input longint unsigned divisor_sq,
                                                     input int shift_sq);
      longint unsigned p;
      longint unsigned sum;
      longint unsigned k;
      p   = first;
      sum = 0;
      k   = 0;
      while (p != 0) begin
         if (k[0]) sum = sum - p / (2 * k + 1);
         else sum = sum + p / (2 * k + 1);
         if (shift_sq > 0) p = (shift_sq < 64) ? (p >> shift_sq) : 0;
         else p = p / divisor_sq;
         k++;
      end
      return sum;
   endfunction

   // Angle table: pi/4 by Machin's formula, then atan(2^-i).
   task automatic fill_atan_table();
      longint unsigned one_q;
      one_q = 64'd1 << Q_ANGLE;
      atan_q60[0] = 4 * arctan_series(one_q / 5, 25, 0) - arctan_series(one_q / 239, 57121, 0);
      for (int i = 1; i < ROTATIONS; i++)
         atan_q60[i] = arctan_series(one_q >> i, 0, 2 * i);
   endtask

   // Shifts a wide normal so its largest magnitude is below 2^30, truncating toward zero.
   function automatic vec3_type shrink_normal(input wide_type c0, input wide_type c1,
                                              input wide_type c2);
      wide_type  comp[3];
      wide_type  mag;
      int        maxlen;
      int        s;
      vec3_type  r;
      comp[0] = c0;
      comp[1] = c1;
      comp[2] = c2;
      maxlen  = 0;
      for (int i = 0; i < 3; i++) begin
         mag = comp[i] < 0 ? -comp[i] : comp[i];
         for (int b = 127; b >= 0; b--)
            if (mag[b] && b + 1 > maxlen) maxlen = b + 1;
      end
      s = maxlen > SCALE_BITS ? maxlen - SCALE_BITS : 0;
      for (int i = 0; i < 3; i++) begin
         mag  = comp[i] < 0 ? -comp[i] : comp[i];
         mag  = mag >> s;
         r[i] = comp[i] < 0 ? -mag[63:0] : mag[63:0];
      end
      return r;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC on (dot, cross length); a negative dot is pre-rotated by pi/2.
   function automatic longint unsigned cordic_angle(input longint x, input longint unsigned y);
      longint unsigned ux;
      longint unsigned uy;
      longint unsigned m;
      longint cx;
      longint cy;
      longint sx;
      longint sy;
      longint z;
      longint base;
      ux   = x < 0 ? -x : x;
      uy   = y;
      z    = 0;
      base = 0;
      m    = ux > uy ? ux : uy;
      if (m == 0) return 0;
      while (m >= (64'd1 << 59)) begin
         ux = ux >> 1; uy = uy >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 58)) begin
         ux = ux << 1; uy = uy << 1; m = m << 1;
      end
      if (x < 0) begin
         cx = uy; cy = ux; base = 2 * atan_q60[0];
      end else begin
         cx = ux; cy = uy;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         sx = cx >>> i;
         sy = cy >>> i;
         if (cy >= 0) begin
            cx = cx + sy; cy = cy - sx; z = z + atan_q60[i];
         end else begin
            cx = cx - sy; cy = cy + sx; z = z - atan_q60[i];
         end
      end
      z = base + z;
      return z < 0 ? 0 : z;
   endfunction

   // Torsion angle of one request: exact normals, scaled dot and cross, CORDIC, rounding.
   function automatic torsion_type torsion_of(input quad_type qd);
      wide_type  pt[4][3];
      wide_type  ba[3];
      wide_type  cb[3];
      wide_type  dc[3];
      vec3_type  tv;
      vec3_type  uv;
      longint t[3];
      longint u[3];
      longint w[3];
      longint dot;
      longint unsigned wm;
      longint unsigned maxw;
      longint unsigned sum;
      longint unsigned y;
      longint unsigned half;
      longint unsigned q;
      longint unsigned piq;
      int     len;
      int     sc;
      torsion_type res;
      for (int i = 0; i < 12; i++) pt[i / 3][i % 3] = $signed(qd[i]);
      for (int i = 0; i < 3; i++) begin
         ba[i] = pt[1][i] - pt[0][i];
         cb[i] = pt[2][i] - pt[1][i];
         dc[i] = pt[3][i] - pt[2][i];
      end
      tv = shrink_normal(ba[1] * cb[2] - ba[2] * cb[1], ba[2] * cb[0] - ba[0] * cb[2],
                         ba[0] * cb[1] - ba[1] * cb[0]);
      uv = shrink_normal(cb[1] * dc[2] - cb[2] * dc[1], cb[2] * dc[0] - cb[0] * dc[2],
                         cb[0] * dc[1] - cb[1] * dc[0]);
      for (int i = 0; i < 3; i++) begin
         t[i] = tv[i];
         u[i] = uv[i];
      end
      res.angle = '0;
      res.degen = 1'b1;
      if ((t[0] == 0 && t[1] == 0 && t[2] == 0) || (u[0] == 0 && u[1] == 0 && u[2] == 0))
         return res;
      dot  = t[0] * u[0] + t[1] * u[1] + t[2] * u[2];
      w[0] = t[1] * u[2] - t[2] * u[1];
      w[1] = t[2] * u[0] - t[0] * u[2];
      w[2] = t[0] * u[1] - t[1] * u[0];
      maxw = 0;
      for (int i = 0; i < 3; i++) begin
         wm = w[i] < 0 ? -w[i] : w[i];
         if (wm > maxw) maxw = wm;
      end
      len = 0;
      for (int b = 63; b >= 0; b--)
         if (maxw[b] && len == 0) len = b + 1;
      sc  = len > SCALE_BITS ? len - SCALE_BITS : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         wm  = w[i] < 0 ? -w[i] : w[i];
         wm  = wm >> sc;
         sum = sum + wm * wm;
      end
      y    = floor_sqrt(sum) << sc;
      half = 64'd1 << (Q_ANGLE - 1 - ANGLE_BITS);
      q    = (cordic_angle(dot, y) + half) >> (Q_ANGLE - ANGLE_BITS);
      piq  = (4 * atan_q60[0] + half) >> (Q_ANGLE - ANGLE_BITS);
      if (q > piq) q = piq;
      res.angle = q[ANGLE_W-1:0];
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic quad_type make_quad(input int a0, input int a1, input int a2,
                                          input int b0, input int b1, input int b2,
                                          input int c0, input int c1, input int c2,
                                          input int d0, input int d1, input int d2);
      return {d2, d1, d0, c2, c1, c0, b2, b1, b0, a2, a1, a0};
   endfunction

   // Random coordinates: full range, or small values at a random scale.
   function automatic int rand_coord(input bit full);
      int v;
      if (full) return $urandom;
      v = $urandom_range(0, 200) - 100;
      return v <<< $urandom_range(0, 20);
   endfunction

   function automatic quad_type random_quad();
      quad_type qd;
      int    base[3];
      int    dir[3];
      int    kind;
      bit    full;
      kind = $urandom_range(0, 9);
      full = $urandom_range(0, 2) == 0;
      for (int i = 0; i < 12; i++) qd[i] = rand_coord(full);
      for (int i = 0; i < 3; i++) begin
         base[i] = rand_coord(1'b0);
         dir[i]  = $urandom_range(0, 20) - 10;
      end
      case (kind)
         // Three points on a line, so one normal vanishes.
         0: begin
            for (int k = 0; k < 3; k++)
               for (int i = 0; i < 3; i++)
                  qd[(kind == 0 && full ? k + 1 : k) * 3 + i] = base[i] + k * dir[i] * ONE;
         end
         // All four points in one plane: the angle is zero or pi.
         1: begin
            for (int k = 0; k < 4; k++) qd[k * 3 + 2] = base[2];
         end
         // Two coincident points.
         2: begin
            for (int i = 0; i < 3; i++) qd[6 + i] = qd[3 + i];
         end
         default: ;
      endcase
      return qd;
   endfunction

   // Driver: bursts of requests separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted = torsion_of(drv_quad);
            expected_angles.push_back(predicted);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_quads.size() != 0) begin
               drv_quad <= pending_quads.pop_front();
               start    <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every result against the oldest expected angle; watchdog on idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected result angle=%0d degenerate=%0b", $time,
                        rsp_torsion_angle, rsp_degenerate);
               errors++;
            end else begin
               oldest = expected_angles.pop_front();
               if (rsp_torsion_angle !== oldest.angle) begin
                  $display("%0t: angle expected %0d, got %0d", $time, oldest.angle,
                           rsp_torsion_angle);
                  errors++;
               end
               if (rsp_degenerate !== oldest.degen) begin
                  $display("%0t: degenerate expected %0b, got %0b", $time, oldest.degen,
                           rsp_degenerate);
                  errors++;
               end
            end
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      drv_quad    = '0;
      errors      = 0;
      idle_cycles = 0;
      burst_left  = 5;
      gap_left    = 0;
      fill_atan_table();

      // Directed requests: extremes, degenerate and planar cases, right angle.
      pending_quads.push_back('0);
      pending_quads.push_back({12{32'h7FFF_FFFF}});
      pending_quads.push_back({12{32'h8000_0000}});
      pending_quads.push_back(make_quad(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_quads.push_back(make_quad(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      pending_quads.push_back(make_quad(0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, ONE, 0));
      pending_quads.push_back(make_quad(0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, -ONE, 0));
      pending_quads.push_back(make_quad(0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, ONE));
      pending_quads.push_back(make_quad(0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, -ONE));
      pending_quads.push_back(make_quad(0, ONE, 0, 0, 0, 0, ONE, 0, 0, ONE, ONE, ONE));
      pending_quads.push_back(make_quad(-ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 7, 3, 5));
      pending_quads.push_back(make_quad(1, 2, 3, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
      pending_quads.push_back(make_quad(0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1));
      pending_quads.push_back(make_quad(0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0));
      pending_quads.push_back(make_quad(0, 1, 0, 0, 0, 0, 1, 0, 0, 1, -1, 1));
      pending_quads.push_back(make_quad(5, 5, 5, 5, 5, 5, 1, 2, 3, 4, 5, 6));
      pending_quads.push_back(make_quad(-1, -1, -1, 32'h7FFF_FFFF, 0, 0,
                                        0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));

      // Random requests.
      for (int n = 0; n < RANDOM_REQS; n++) pending_quads.push_back(random_quad());

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_quads.size() != 0 || start) @(posedge clock);
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
